// ===== rtl/jhip_pkg.sv =====
// Shared types and constants for the JPEG header info parser.
`timescale 1ns / 1ps
`default_nettype none
package jhip_pkg;

  localparam int unsigned DIM_W    = 16;
  localparam int unsigned FMT_W    = 3;
  localparam int unsigned STAT_W   = 3;
  localparam int unsigned OUT_DW   = 40;

  localparam logic [DIM_W-1:0] MAX_DIM_RST = 16'd8192;

  localparam logic [7:0] BYTE_PREFIX = 8'hff;
  localparam logic [7:0] MK_SOF0     = 8'hc0;
  localparam logic [7:0] MK_SOF2     = 8'hc2;
  localparam logic [7:0] MK_SOI      = 8'hd8;
  localparam logic [7:0] MK_SOS      = 8'hda;
  localparam logic [7:0] MK_DRI      = 8'hdd;

  localparam logic [STAT_W-1:0] ST_SOS    = 3'd0;
  localparam logic [STAT_W-1:0] ST_NOMK   = 3'd1;
  localparam logic [STAT_W-1:0] ST_ENDED  = 3'd2;
  localparam logic [STAT_W-1:0] ST_PROG   = 3'd3;
  localparam logic [STAT_W-1:0] ST_WIDTH  = 3'd4;
  localparam logic [STAT_W-1:0] ST_HEIGHT = 3'd5;
  localparam logic [STAT_W-1:0] ST_COMP   = 3'd6;

  localparam logic [FMT_W-1:0] FMT_420  = 3'd0;
  localparam logic [FMT_W-1:0] FMT_422H = 3'd1;
  localparam logic [FMT_W-1:0] FMT_422V = 3'd2;
  localparam logic [FMT_W-1:0] FMT_444  = 3'd3;
  localparam logic [FMT_W-1:0] FMT_400  = 3'd4;

  typedef struct packed {
    logic              clear;
    logic              ld_skip_hi;
    logic              ld_skip_lo;
    logic              set_skip4;
    logic              dec_skip;
    logic              ld_hh;
    logic              ld_hl;
    logic              ld_wh;
    logic              ld_wl;
    logic              ld_nc;
    logic              ld_samp;
    logic              inc_idx;
    logic              finish;
    logic              clr_found;
    logic              emit;
    logic [STAT_W-1:0] status;
  } jhip_cmd_t;

  typedef struct packed {
    logic skip_len_zero;
    logic skip_dec_zero;
    logic width_over;
    logic height_over;
    logic comp_last;
  } jhip_stat_t;

endpackage
`default_nettype wire

// ===== rtl/jpeg_header_info_parser_core.sv =====
// Top level of the JPEG SOF0 header info parser.
`timescale 1ns / 1ps
`default_nettype none
// Parses a JPEG byte stream one byte per cycle unless intake stalls: each
// accepted byte moves the one-hot phase register by one step and updates the
// frame registers. The result of a parse is registered and shows on the output
// in the cycle after the byte that ends the parse or carries in_tlast. It sits
// in a single output register, and intake stalls in exactly the cycles where
// that register holds a result and out_tready is low. Bytes after the end of a
// parse are consumed without a result until in_tlast, which rearms the parser.
// max_dimension is written through cfg_wr_en/cfg_wr_data; the user must write
// it only while no file is in flight, as the block does not enforce this.
module jpeg_header_info_parser_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tlast,   // last_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [15:0] frame_width, [31:16] frame_height,
                                       // [34:32] pixel_fmt, [39:35] zero
  output logic [3:0]       out_tuser,  // [0] frame_ok, [3:1] end_status
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data // max_dimension
);
  import jhip_pkg::*;

  jhip_cmd_t  cmd;
  jhip_stat_t stat;
  logic       in_rdy;
  logic       acc;

  assign in_tready = in_rdy;
  assign acc       = in_tvalid && in_rdy;

  jhip_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .data_byte (in_tdata),
    .last_byte (in_tlast),
    .stat      (stat),
    .cmd       (cmd)
  );

  jhip_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .data_byte   (in_tdata),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .in_rdy      (in_rdy)
  );

endmodule
`default_nettype wire

// ===== rtl/jhip_ctrl.sv =====
// Marker and segment phase controller of the JPEG header parser.
`timescale 1ns / 1ps
`default_nettype none
module jhip_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                acc,
  input  wire logic [7:0]          data_byte,
  input  wire logic                last_byte,
  input  wire jhip_pkg::jhip_stat_t stat,
  output jhip_pkg::jhip_cmd_t      cmd
);
  import jhip_pkg::*;

  typedef enum logic [16:0] {
    S_FF    = 17'h00001,
    S_MARK  = 17'h00002,
    S_LENH  = 17'h00004,
    S_LENL  = 17'h00008,
    S_SKIP  = 17'h00010,
    S_FLENH = 17'h00020,
    S_FLENL = 17'h00040,
    S_PREC  = 17'h00080,
    S_HH    = 17'h00100,
    S_HL    = 17'h00200,
    S_WH    = 17'h00400,
    S_WL    = 17'h00800,
    S_NC    = 17'h01000,
    S_CID   = 17'h02000,
    S_SAMP  = 17'h04000,
    S_TQ    = 17'h08000,
    S_DONE  = 17'h10000
  } state_t;

  state_t            state_r, state_nxt, adv_nxt;
  logic              term;
  logic [STAT_W-1:0] term_stat;

  always_comb begin
    cmd       = '0;
    adv_nxt   = state_r;
    term      = 1'b0;
    term_stat = ST_SOS;
    unique case (state_r)
      S_FF: begin
        if (data_byte != BYTE_PREFIX) begin
          term      = 1'b1;
          term_stat = ST_NOMK;
        end else begin
          adv_nxt = S_MARK;
        end
      end
      S_MARK: begin
        priority if (data_byte == MK_SOS) begin
          term      = 1'b1;
          term_stat = ST_SOS;
        end else if (data_byte == MK_SOI) begin
          adv_nxt = S_FF;
        end else if (data_byte == MK_DRI) begin
          cmd.set_skip4 = 1'b1;
          adv_nxt       = S_SKIP;
        end else if (data_byte == MK_SOF2) begin
          cmd.clr_found = 1'b1;
          term          = 1'b1;
          term_stat     = ST_PROG;
        end else if (data_byte == MK_SOF0) begin
          adv_nxt = S_FLENH;
        end else begin
          adv_nxt = S_LENH;
        end
      end
      S_LENH: begin
        cmd.ld_skip_hi = 1'b1;
        adv_nxt        = S_LENL;
      end
      S_LENL: begin
        cmd.ld_skip_lo = 1'b1;
        adv_nxt        = stat.skip_len_zero ? S_FF : S_SKIP;
      end
      S_SKIP: begin
        cmd.dec_skip = 1'b1;
        adv_nxt      = stat.skip_dec_zero ? S_FF : S_SKIP;
      end
      S_FLENH: adv_nxt = S_FLENL;
      S_FLENL: adv_nxt = S_PREC;
      S_PREC:  adv_nxt = S_HH;
      S_HH: begin
        cmd.ld_hh = 1'b1;
        adv_nxt   = S_HL;
      end
      S_HL: begin
        cmd.ld_hl = 1'b1;
        adv_nxt   = S_WH;
      end
      S_WH: begin
        cmd.ld_wh = 1'b1;
        adv_nxt   = S_WL;
      end
      S_WL: begin
        cmd.ld_wl = 1'b1;
        priority if (stat.width_over) begin
          cmd.clr_found = 1'b1;
          term          = 1'b1;
          term_stat     = ST_WIDTH;
        end else if (stat.height_over) begin
          cmd.clr_found = 1'b1;
          term          = 1'b1;
          term_stat     = ST_HEIGHT;
        end else begin
          adv_nxt = S_NC;
        end
      end
      S_NC: begin
        cmd.ld_nc = 1'b1;
        priority if (data_byte > 8'd3) begin
          cmd.clr_found = 1'b1;
          term          = 1'b1;
          term_stat     = ST_COMP;
        end else if (data_byte == 8'd0) begin
          cmd.finish = 1'b1;
          adv_nxt    = S_FF;
        end else begin
          adv_nxt = S_CID;
        end
      end
      S_CID: adv_nxt = S_SAMP;
      S_SAMP: begin
        cmd.ld_samp = 1'b1;
        adv_nxt     = S_TQ;
      end
      S_TQ: begin
        if (stat.comp_last) begin
          cmd.finish = 1'b1;
          adv_nxt    = S_FF;
        end else begin
          cmd.inc_idx = 1'b1;
          adv_nxt     = S_CID;
        end
      end
      S_DONE: adv_nxt = S_DONE;
      default: adv_nxt = S_FF;
    endcase

    if (term) begin
      adv_nxt = S_DONE;
    end
    cmd.status = term ? term_stat : ST_ENDED;
    cmd.emit   = (state_r != S_DONE) && (term || last_byte);
    cmd.clear  = last_byte;
    state_nxt  = last_byte ? S_FF : adv_nxt;

    if (!acc) begin
      cmd       = '0;
      state_nxt = state_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_FF;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/jhip_dpath.sv =====
// Frame header registers, format decision and result register.
`timescale 1ns / 1ps
`default_nettype none
module jhip_dpath (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [7:0]                data_byte,
  input  wire jhip_pkg::jhip_cmd_t       cmd,
  output jhip_pkg::jhip_stat_t           stat,
  input  wire logic                      cfg_wr_en,
  input  wire logic [jhip_pkg::DIM_W-1:0] cfg_wr_data,
  input  wire logic                      out_tready,
  output logic                           out_tvalid,
  output logic [jhip_pkg::OUT_DW-1:0]    out_tdata,
  output logic [jhip_pkg::STAT_W:0]      out_tuser,
  output logic                           in_rdy
);
  import jhip_pkg::*;

  logic [DIM_W-1:0]  maxd_r;
  logic [DIM_W-1:0]  skip_r, skip_nxt;
  logic [DIM_W-1:0]  hgt_r, hgt_nxt;
  logic [DIM_W-1:0]  wid_r, wid_nxt;
  logic [7:0]        cnt_r, cnt_nxt;
  logic [1:0]        idx_r, idx_nxt;
  logic [7:0]        sf0_r, sf0_nxt;
  logic [7:0]        sf1_r, sf1_nxt;
  logic              found_r, found_nxt;
  logic [FMT_W-1:0]  fmt_r, fmt_nxt;
  logic              ovld_r;
  logic              ofound_r;
  logic [DIM_W-1:0]  owid_r, ohgt_r;
  logic [FMT_W-1:0]  ofmt_r;
  logic [STAT_W-1:0] ostat_r;

  logic [DIM_W-1:0]  len_full;
  logic [7:0]        prod_l, prod_c;
  logic [10:0]       d1, d2, d3, d4, d5, pl;
  logic [FMT_W-1:0]  ratio_fmt;
  logic [3:0]        h0;

  assign len_full = {skip_r[15:8], data_byte};

  assign stat.skip_len_zero = (len_full == 16'd2);
  assign stat.skip_dec_zero = (skip_r == 16'd1);
  assign stat.width_over    = ({wid_r[15:8], data_byte} > maxd_r);
  assign stat.height_over   = (hgt_r > maxd_r);
  assign stat.comp_last     = ({6'd0, idx_r} + 8'd1 >= cnt_r);

  // luma to chroma block ratio, integer quotient tested by range compares
  assign h0     = sf0_r[3:0];
  assign prod_l = sf0_r[7:4] * sf0_r[3:0];
  assign prod_c = sf1_r[7:4] * sf1_r[3:0];
  assign pl     = {3'd0, prod_l};
  assign d1     = {3'd0, prod_c};
  assign d2     = d1 << 1;
  assign d3     = d2 + d1;
  assign d4     = d1 << 2;
  assign d5     = d4 + d1;

  always_comb begin
    ratio_fmt = FMT_420;
    if (d1 != 11'd0) begin
      priority if (pl >= d4 && pl < d5 && h0 == 4'd2) begin
        ratio_fmt = FMT_420;
      end else if (pl >= d2 && pl < d3 && h0 == 4'd1) begin
        ratio_fmt = FMT_422H;
      end else if (pl >= d2 && pl < d3 && h0 == 4'd2) begin
        ratio_fmt = FMT_422V;
      end else if (pl >= d1 && pl < d2 && h0 == 4'd1) begin
        ratio_fmt = FMT_444;
      end else begin
        ratio_fmt = FMT_420;
      end
    end
  end

  always_comb begin
    skip_nxt  = skip_r;
    hgt_nxt   = hgt_r;
    wid_nxt   = wid_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    sf0_nxt   = sf0_r;
    sf1_nxt   = sf1_r;
    found_nxt = found_r;
    fmt_nxt   = fmt_r;
    if (cmd.set_skip4)  skip_nxt = 16'd4;
    if (cmd.ld_skip_hi) skip_nxt = {data_byte, 8'd0};
    if (cmd.ld_skip_lo) skip_nxt = len_full - 16'd2;
    if (cmd.dec_skip)   skip_nxt = skip_r - 16'd1;
    if (cmd.ld_hh)      hgt_nxt  = {data_byte, 8'd0};
    if (cmd.ld_hl)      hgt_nxt  = {hgt_r[15:8], data_byte};
    if (cmd.ld_wh)      wid_nxt  = {data_byte, 8'd0};
    if (cmd.ld_wl)      wid_nxt  = {wid_r[15:8], data_byte};
    if (cmd.ld_nc) begin
      cnt_nxt = data_byte;
      idx_nxt = 2'd0;
    end
    if (cmd.ld_samp && idx_r == 2'd0) sf0_nxt = data_byte;
    if (cmd.ld_samp && idx_r == 2'd1) sf1_nxt = data_byte;
    if (cmd.inc_idx)    idx_nxt  = idx_r + 2'd1;
    if (cmd.clr_found)  found_nxt = 1'b0;
    if (cmd.finish) begin
      found_nxt = 1'b1;
      fmt_nxt   = (cnt_nxt == 8'd3) ? ratio_fmt : FMT_400;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      skip_r  <= '0;
      hgt_r   <= '0;
      wid_r   <= '0;
      cnt_r   <= '0;
      idx_r   <= '0;
      sf0_r   <= '0;
      sf1_r   <= '0;
      found_r <= 1'b0;
      fmt_r   <= '0;
    end else begin
      skip_r  <= skip_nxt;
      hgt_r   <= hgt_nxt;
      wid_r   <= wid_nxt;
      cnt_r   <= cnt_nxt;
      idx_r   <= idx_nxt;
      sf0_r   <= sf0_nxt;
      sf1_r   <= sf1_nxt;
      found_r <= found_nxt;
      fmt_r   <= fmt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      maxd_r <= MAX_DIM_RST;
    end else if (cfg_wr_en) begin
      maxd_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else if (cmd.emit) begin
      ovld_r <= 1'b1;
    end else if (out_tready) begin
      ovld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      ofound_r <= found_nxt;
      owid_r   <= found_nxt ? wid_nxt : '0;
      ohgt_r   <= found_nxt ? hgt_nxt : '0;
      ofmt_r   <= found_nxt ? fmt_nxt : '0;
      ostat_r  <= cmd.status;
    end
  end

  assign in_rdy     = !ovld_r || out_tready;
  assign out_tvalid = ovld_r;
  assign out_tdata  = {5'd0, ofmt_r, ohgt_r, owid_r};
  assign out_tuser  = {ostat_r, ofound_r};

endmodule
`default_nettype wire

// ===== rtl/jhip_checker.sv =====
// Port-level assertions for the JPEG header parser, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module jhip_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata,
  input wire logic [3:0]  out_tuser
);
  import jhip_pkg::*;

  a_rst_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("held result changed");

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while result blocked");

  a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == 40'd0)
    else $error("payload not zero without frame info");

  a_found_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |->
      out_tuser[3:1] != ST_PROG && out_tuser[3:1] != ST_WIDTH &&
      out_tuser[3:1] != ST_HEIGHT && out_tuser[3:1] != ST_COMP &&
      out_tdata[34:32] <= FMT_400)
    else $error("frame info with error status");

endmodule

bind jpeg_header_info_parser_core jhip_checker u_jhip_checker (.*);
`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for the JPEG SOF0 header info parser.
`timescale 1ns / 1ps
module tb_top;
  import jhip_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned SETTLE = 12;

  typedef enum logic [3:0] {
    P_PREFIX, P_MARKER, P_LEN_HI, P_LEN_LO, P_SKIP, P_FLEN_HI, P_FLEN_LO, P_PREC,
    P_H_HI, P_H_LO, P_W_HI, P_W_LO, P_NCOMP, P_CID, P_SAMP, P_TQ
  } hdr_phase_t;

  typedef struct packed {
    logic              found;
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic [FMT_W-1:0]  fmt;
    logic [STAT_W-1:0] status;
  } hdr_info_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       typed;
    hdr_info_t  info;
  } byte_row_t;

  localparam hdr_info_t NO_INFO = '0;
  localparam hdr_info_t INFO_NOMK = '{1'b0, 16'd0, 16'd0, FMT_420, ST_NOMK};
  localparam hdr_info_t INFO_PROG = '{1'b0, 16'd0, 16'd0, FMT_420, ST_PROG};
  localparam hdr_info_t INFO_WIDTH = '{1'b0, 16'd0, 16'd0, FMT_420, ST_WIDTH};
  localparam hdr_info_t INFO_FRAME = '{1'b1, 16'd32, 16'd16, FMT_400, ST_SOS};

  localparam byte_row_t DIRECTED[25] = '{
    '{8'h00, 1'b0, 1'b1, INFO_NOMK},
    '{8'h55, 1'b1, 1'b0, NO_INFO},
    '{BYTE_PREFIX, 1'b0, 1'b0, NO_INFO},
    '{MK_SOF2, 1'b1, 1'b1, INFO_PROG},
    '{BYTE_PREFIX, 1'b0, 1'b0, NO_INFO},
    '{MK_SOF0, 1'b0, 1'b0, NO_INFO},
    '{8'h00, 1'b0, 1'b0, NO_INFO},
    '{8'h0b, 1'b0, 1'b0, NO_INFO},
    '{8'h08, 1'b0, 1'b0, NO_INFO},
    '{8'h00, 1'b0, 1'b0, NO_INFO},
    '{8'h10, 1'b0, 1'b0, NO_INFO},
    '{8'hff, 1'b0, 1'b0, NO_INFO},
    '{8'hff, 1'b1, 1'b1, INFO_WIDTH},
    '{BYTE_PREFIX, 1'b0, 1'b0, NO_INFO},
    '{MK_SOF0, 1'b0, 1'b0, NO_INFO},
    '{8'h00, 1'b0, 1'b0, NO_INFO},
    '{8'h08, 1'b0, 1'b0, NO_INFO},
    '{8'h08, 1'b0, 1'b0, NO_INFO},
    '{8'h00, 1'b0, 1'b0, NO_INFO},
    '{8'h10, 1'b0, 1'b0, NO_INFO},
    '{8'h00, 1'b0, 1'b0, NO_INFO},
    '{8'h20, 1'b0, 1'b0, NO_INFO},
    '{8'h00, 1'b0, 1'b0, NO_INFO},
    '{BYTE_PREFIX, 1'b0, 1'b0, NO_INFO},
    '{MK_SOS, 1'b1, 1'b1, INFO_FRAME}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [3:0]  out_tuser;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  jpeg_header_info_parser_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // parser shadow state
  hdr_phase_t       hp_phase;
  logic [15:0]      hp_skip;
  logic [15:0]      hp_width;
  logic [15:0]      hp_height;
  logic [7:0]       hp_ncomp;
  logic [1:0]       hp_cidx;
  logic [7:0]       hp_samp[2];
  logic             hp_found;
  logic [FMT_W-1:0] hp_fmt;
  logic             hp_done;
  logic [15:0]      hp_max_dim;

  hdr_info_t   info_q[$];
  logic [8:0]  file_q[$];   // {last, data}
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned stall_left = 0;
  hdr_info_t   seen_info;
  hdr_info_t   head_info;

  assign seen_info = {out_tuser[0], out_tdata[15:0], out_tdata[31:16], out_tdata[34:32],
                      out_tuser[3:1]};

  task automatic clear_parser();
    hp_phase = P_PREFIX;
    hp_skip = '0;
    hp_width = '0;
    hp_height = '0;
    hp_ncomp = '0;
    hp_cidx = '0;
    hp_samp[0] = '0;
    hp_samp[1] = '0;
    hp_found = 1'b0;
    hp_fmt = '0;
    hp_done = 1'b0;
  endtask

  function automatic logic [FMT_W-1:0] chroma_format();
    int unsigned w0, h0, w1, h1, area, ratio;
    w0 = hp_samp[0][7:4];
    h0 = hp_samp[0][3:0];
    w1 = hp_samp[1][7:4];
    h1 = hp_samp[1][3:0];
    area = w1 * h1;
    if (area == 0) return FMT_420;
    ratio = (w0 * h0) / area;
    if (ratio == 4 && h0 == 2) return FMT_420;
    if (ratio == 2 && h0 == 1) return FMT_422H;
    if (ratio == 2 && h0 == 2) return FMT_422V;
    if (ratio == 1 && h0 == 1) return FMT_444;
    return FMT_420;
  endfunction

  task automatic close_frame();
    hp_fmt = (hp_ncomp == 8'd3) ? chroma_format() : FMT_400;
    hp_found = 1'b1;
    hp_phase = P_PREFIX;
  endtask

  task automatic advance_parser(input logic [7:0] b, output bit ended,
                                output logic [STAT_W-1:0] st);
    ended = 1'b0;
    st = ST_SOS;
    case (hp_phase)
      P_PREFIX: begin
        if (b != BYTE_PREFIX) begin
          ended = 1'b1;
          st = ST_NOMK;
        end else hp_phase = P_MARKER;
      end
      P_MARKER: begin
        if (b == MK_SOS) begin
          ended = 1'b1;
          st = ST_SOS;
        end else if (b == MK_SOI) begin
          hp_phase = P_PREFIX;
        end else if (b == MK_DRI) begin
          hp_skip = 16'd4;
          hp_phase = P_SKIP;
        end else if (b == MK_SOF2) begin
          hp_found = 1'b0;
          ended = 1'b1;
          st = ST_PROG;
        end else hp_phase = (b == MK_SOF0) ? P_FLEN_HI : P_LEN_HI;
      end
      P_LEN_HI: begin
        hp_skip = {b, 8'h00};
        hp_phase = P_LEN_LO;
      end
      P_LEN_LO: begin
        hp_skip = (hp_skip | {8'h00, b}) - 16'd2;
        hp_phase = (hp_skip == 16'd0) ? P_PREFIX : P_SKIP;
      end
      P_SKIP: begin
        hp_skip = hp_skip - 16'd1;
        if (hp_skip == 16'd0) hp_phase = P_PREFIX;
      end
      P_FLEN_HI: hp_phase = P_FLEN_LO;
      P_FLEN_LO: hp_phase = P_PREC;
      P_PREC: hp_phase = P_H_HI;
      P_H_HI: begin
        hp_height = {b, 8'h00};
        hp_phase = P_H_LO;
      end
      P_H_LO: begin
        hp_height = hp_height | {8'h00, b};
        hp_phase = P_W_HI;
      end
      P_W_HI: begin
        hp_width = {b, 8'h00};
        hp_phase = P_W_LO;
      end
      P_W_LO: begin
        hp_width = hp_width | {8'h00, b};
        if (hp_width > hp_max_dim) begin
          hp_found = 1'b0;
          ended = 1'b1;
          st = ST_WIDTH;
        end else if (hp_height > hp_max_dim) begin
          hp_found = 1'b0;
          ended = 1'b1;
          st = ST_HEIGHT;
        end else hp_phase = P_NCOMP;
      end
      P_NCOMP: begin
        hp_ncomp = b;
        hp_cidx = '0;
        if (b > 8'd3) begin
          hp_found = 1'b0;
          ended = 1'b1;
          st = ST_COMP;
        end else if (b == 8'd0) close_frame();
        else hp_phase = P_CID;
      end
      P_CID: hp_phase = P_SAMP;
      P_SAMP: begin
        if (hp_cidx < 2'd2) hp_samp[hp_cidx[0]] = b;
        hp_phase = P_TQ;
      end
      P_TQ: begin
        if (int'(hp_cidx) + 1 >= int'(hp_ncomp)) close_frame();
        else begin
          hp_cidx = hp_cidx + 2'd1;
          hp_phase = P_CID;
        end
      end
      default: hp_phase = P_PREFIX;
    endcase
  endtask

  task automatic predict_byte(input logic [7:0] b, input logic l, output bit got,
                              output hdr_info_t r);
    bit ended;
    logic [STAT_W-1:0] st;
    got = 1'b0;
    r = '0;
    if (!hp_done) begin
      advance_parser(b, ended, st);
      if (ended || l) begin
        got = 1'b1;
        r.found = hp_found;
        r.width = hp_found ? hp_width : '0;
        r.height = hp_found ? hp_height : '0;
        r.fmt = hp_found ? hp_fmt : '0;
        r.status = ended ? st : ST_ENDED;
        if (ended) hp_done = 1'b1;
      end
    end
    if (l) clear_parser();
  endtask

  task automatic put_byte(input logic [7:0] b, input logic l);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(11, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= l;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic feed_byte(input logic [7:0] b, input logic l);
    bit got;
    hdr_info_t r;
    predict_byte(b, l, got, r);
    if (got) info_q.push_back(r);
    put_byte(b, l);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (info_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_max_dim(input logic [15:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    hp_max_dim = v;
  endtask

  function automatic logic [15:0] pick_dim();
    case ($urandom_range(9))
      0: return 16'd0;
      1: return 16'd1;
      2: return hp_max_dim;
      3: return (hp_max_dim == 16'hffff) ? 16'hffff : hp_max_dim + 16'd1;
      4: return 16'hffff;
      5: return 16'($urandom);
      default: return 16'($urandom_range(hp_max_dim, 0));
    endcase
  endfunction

  function automatic logic [7:0] pick_samp();
    case ($urandom_range(7))
      0: return 8'h11;
      1: return 8'h21;
      2: return 8'h12;
      3: return 8'h22;
      4: return 8'h41;
      5: return 8'h14;
      6: return 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_ncomp();
    case ($urandom_range(9))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd2;
      7: return 8'd4;
      8: return 8'($urandom_range(255, 5));
      default: return 8'd3;
    endcase
  endfunction

  task automatic add_byte(input logic [7:0] b);
    file_q.push_back({1'b0, b});
  endtask

  task automatic add_misc_segment();
    logic [7:0] mk;
    int unsigned len;
    if ($urandom_range(3) == 0) begin
      add_byte(BYTE_PREFIX);
      add_byte(MK_DRI);
      repeat (4) add_byte(8'($urandom));
    end else begin
      do mk = 8'($urandom);
      while (mk == MK_SOF0 || mk == MK_SOF2 || mk == MK_SOI || mk == MK_SOS || mk == MK_DRI);
      len = $urandom_range(12, 2);
      add_byte(BYTE_PREFIX);
      add_byte(mk);
      add_byte(len[15:8]);
      add_byte(len[7:0]);
      repeat (len - 2) add_byte(8'($urandom));
    end
  endtask

  task automatic add_sof0();
    logic [15:0] h, w;
    logic [7:0] nc;
    h = pick_dim();
    w = pick_dim();
    nc = pick_ncomp();
    add_byte(BYTE_PREFIX);
    add_byte(MK_SOF0);
    repeat (3) add_byte(8'($urandom));
    add_byte(h[15:8]);
    add_byte(h[7:0]);
    add_byte(w[15:8]);
    add_byte(w[7:0]);
    add_byte(nc);
    for (int i = 0; i < int'(nc) && i < 4; i++) begin
      add_byte(8'($urandom));
      add_byte(pick_samp());
      add_byte(8'($urandom));
    end
  endtask

  task automatic build_file();
    int unsigned kind, cut, pos;
    file_q.delete();
    kind = $urandom_range(99);
    if (kind >= 90) begin
      repeat ($urandom_range(8, 1)) add_byte(8'($urandom));
    end else begin
      if ($urandom_range(3) != 0) begin
        add_byte(BYTE_PREFIX);
        add_byte(MK_SOI);
      end
      repeat ($urandom_range(2)) add_misc_segment();
      if ($urandom_range(9) == 0) begin
        add_byte(BYTE_PREFIX);
        add_byte(MK_SOF2);
      end else add_sof0();
      if ($urandom_range(7) == 0) add_sof0();
      repeat ($urandom_range(1)) add_misc_segment();
      if ($urandom_range(5) != 0) begin
        add_byte(BYTE_PREFIX);
        add_byte(MK_SOS);
      end
      repeat ($urandom_range(3)) add_byte(8'($urandom));
      if (kind >= 65 && kind < 80) begin
        cut = $urandom_range(file_q.size() - 1, 1);
        while (file_q.size() > cut) void'(file_q.pop_back());
      end else if (kind >= 80) begin
        pos = $urandom_range(file_q.size() - 1);
        file_q[pos][7:0] = 8'($urandom);
      end
    end
    file_q[file_q.size() - 1][8] = 1'b1;
  endtask

  task automatic run_file(inout int unsigned fed);
    foreach (file_q[i]) feed_byte(file_q[i][7:0], file_q[i][8]);
    fed += file_q.size();
  endtask

  task automatic run_phase(input int unsigned items, input int unsigned idle_max);
    int unsigned fed, g, s;
    fed = 0;
    g = $urandom_range(idle_max);
    s = $urandom_range(idle_max);
    while (fed < items) begin
      build_file();
      if ($urandom_range(5) == 0) begin
        gap_pct = 0;
        stall_pct = 0;
      end else begin
        gap_pct = g;
        stall_pct = s;
      end
      run_file(fed);
    end
    drain();
  endtask

  function automatic string info_str(input hdr_info_t i);
    return $sformatf("found=%0d width=%0d height=%0d format=%0d status=%0d",
                     i.found, i.width, i.height, i.fmt, i.status);
  endfunction

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
      stall_left <= $urandom_range(10, 0);
      out_tready <= 1'b0;
    end else out_tready <= 1'b1;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (info_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, got %s", $time, info_str(seen_info));
      end else begin
        head_info = info_q.pop_front();
        if (seen_info !== head_info) begin
          errors++;
          $display("%0t: result mismatch: expected %s, got %s", $time, info_str(head_info),
                   info_str(seen_info));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    bit got;
    hdr_info_t r;
    int unsigned fed;
    clear_parser();
    hp_max_dim = MAX_DIM_RST;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    gap_pct = 20;
    stall_pct = 20;
    foreach (DIRECTED[i]) begin
      predict_byte(DIRECTED[i].data, DIRECTED[i].last, got, r);
      if (DIRECTED[i].typed) info_q.push_back(DIRECTED[i].info);
      else if (got) info_q.push_back(r);
      put_byte(DIRECTED[i].data, DIRECTED[i].last);
    end
    drain();

    run_phase(170, 40);
    set_max_dim(16'hffff);
    run_phase(170, 40);
    set_max_dim(16'd1);
    run_phase(170, 40);
    set_max_dim(16'($urandom_range(65534, 2)));
    run_phase(170, 40);
    set_max_dim(MAX_DIM_RST);
    run_phase(170, 40);

    // no idling from here on; length fields 0 and 1 wrap to long skips cut by the last byte
    gap_pct = 0;
    stall_pct = 0;
    fed = 0;
    file_q.delete();
    add_byte(BYTE_PREFIX);
    add_byte(8'he1);
    add_byte(8'h00);
    add_byte(8'h00);
    repeat (40) add_byte(8'($urandom));
    add_byte(BYTE_PREFIX);
    add_byte(MK_SOS);
    file_q[file_q.size() - 1][8] = 1'b1;
    run_file(fed);
    file_q.delete();
    add_byte(BYTE_PREFIX);
    add_byte(8'he2);
    add_byte(8'h00);
    add_byte(8'h01);
    repeat (40) add_byte(8'($urandom));
    file_q[file_q.size() - 1][8] = 1'b1;
    run_file(fed);
    fed = 0;
    while (fed < 60) begin
      build_file();
      run_file(fed);
    end
    drain();

    if (errors == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

endmodule
